// File: rtl/core/wdrl_pkg.sv
// Shared types, codes and helpers for the word dictionary rank lookup block.
// No dependencies; imported by the controller, datapath and top level.
package wdrl_pkg;

	localparam int DEFAULT_TABLE_DEPTH = 1024;
	localparam int DEFAULT_WORD_CHARS  = 8;
	localparam int WORD_W              = 64;
	localparam int LEN_W               = 4;
	localparam int POS_W               = 10;
	localparam int CNT_W               = 11;

	// Item function codes
	localparam logic [1:0] FUNC_CLEAR = 2'd0;
	localparam logic [1:0] FUNC_LOAD  = 2'd1;
	localparam logic [1:0] FUNC_QUERY = 2'd2;
	localparam logic [1:0] FUNC_NONE  = 2'd3;

	// Result status codes
	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_FULL   = 2'd1;
	localparam logic [1:0] STAT_MISS   = 2'd2;
	localparam logic [1:0] STAT_BADLEN = 2'd3;

	typedef struct packed {
		logic [1:0]        func;
		logic [WORD_W-1:0] word;
		logic [LEN_W-1:0]  word_length;
	} in_item_t;

	typedef struct packed {
		logic [1:0]       status;
		logic             found;
		logic [POS_W-1:0] position;
		logic [CNT_W-1:0] bucket_count;
	} out_item_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_RESP
	} ctrl_state_t;

	// Controller to datapath
	typedef struct packed {
		logic immediate;    // accepted item finishes this cycle
		logic start_query;  // latch query word and reset the scan
		logic rd_en;        // read the entry at the scan address
		logic query_done;   // load the query result into the output register
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic query_ok;   // offered item is a query with a legal length
		logic fill_zero;  // table is empty
		logic addr_last;  // scan address points at the last stored entry
	} dp_stat_t;

	// Zero every character byte past len (first character in the top byte).
	function automatic logic [WORD_W-1:0] mask_word(input logic [WORD_W-1:0] w,
			input logic [LEN_W-1:0] len);
		logic [WORD_W-1:0] m;
		m = '0;
		for (int i = 0; i < WORD_W / 8; i++) begin
			if (LEN_W'(i) < len) begin
				m[WORD_W-1-8*i -: 8] = w[WORD_W-1-8*i -: 8];
			end
		end
		return m;
	endfunction

endpackage

// File: rtl/core/wdrl_ctrl.sv
// Controller state machine for the word dictionary rank lookup block.
// Depends on wdrl_pkg; drives datapath commands and both handshakes.
module wdrl_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	input  wdrl_pkg::dp_stat_t stat,
	output wdrl_pkg::dp_cmd_t  cmd
);
	import wdrl_pkg::*;

	ctrl_state_t state_q, state_d;
	logic        out_valid_q;
	logic        accept;

	// Take a new item only when idle and the output register is free or draining.
	assign in_stall  = !((state_q == S_IDLE) && (!out_valid_q || !out_stall));
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (stat.query_ok) begin
						cmd.start_query = 1'b1;
						state_d = stat.fill_zero ? S_DRAIN : S_SCAN;
					end else begin
						cmd.immediate = 1'b1;
					end
				end
			end
			S_SCAN: begin
				cmd.rd_en = 1'b1;
				if (stat.addr_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_RESP;
			end
			S_RESP: begin
				cmd.query_done = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.immediate || cmd.query_done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// File: rtl/core/wdrl_dp.sv
// Datapath for the word dictionary rank lookup block: entry memory, bucket
// counters, scan compare and the result register. Depends on wdrl_pkg.
module wdrl_dp #(
	parameter int TABLE_DEPTH = wdrl_pkg::DEFAULT_TABLE_DEPTH,
	parameter int WORD_CHARS  = wdrl_pkg::DEFAULT_WORD_CHARS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  wdrl_pkg::in_item_t  in_item,
	input  wdrl_pkg::dp_cmd_t   cmd,
	output wdrl_pkg::dp_stat_t  stat,
	output wdrl_pkg::out_item_t out_item
);
	import wdrl_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int WW = 8 * WORD_CHARS;
	localparam int SW = (WORD_CHARS > 1) ? $clog2(WORD_CHARS) : 1;
	localparam int EW = WW + LEN_W;

	logic [EW-1:0]     mem_q [TABLE_DEPTH];
	logic [EW-1:0]     rd_data_s1;
	logic              rd_valid_s1;
	logic [CW-1:0]     fill_q;
	logic [CW-1:0]     cnt_q [WORD_CHARS];
	logic [AW-1:0]     addr_q;
	logic [WW-1:0]     qword_q;
	logic [LEN_W-1:0]  qlen_q;
	logic [SW-1:0]     qslot_q;
	logic [CW-1:0]     smaller_q;
	logic              hit_q;
	out_item_t         out_q;

	logic              len_ok;
	logic [SW-1:0]     slot;
	logic [WORD_W-1:0] masked;
	logic [WW-1:0]     in_word_m;
	logic [CW-1:0]     slot_cnt;
	logic              full;
	logic              do_load;
	logic              do_clear;
	out_item_t         imm_res;
	out_item_t         qry_res;
	logic [WW-1:0]     ent_word;
	logic [LEN_W-1:0]  ent_len;

	assign len_ok    = (in_item.word_length != '0)
		&& (in_item.word_length <= LEN_W'(WORD_CHARS));
	assign slot      = SW'(in_item.word_length - LEN_W'(1));
	assign masked    = mask_word(in_item.word, in_item.word_length);
	assign in_word_m = masked[WORD_W-1 -: WW];
	assign slot_cnt  = len_ok ? cnt_q[slot] : '0;
	assign full      = (fill_q == CW'(TABLE_DEPTH));
	assign do_load   = cmd.immediate && (in_item.func == FUNC_LOAD) && len_ok && !full;
	assign do_clear  = cmd.immediate && (in_item.func == FUNC_CLEAR);

	assign stat.query_ok  = (in_item.func == FUNC_QUERY) && len_ok;
	assign stat.fill_zero = (fill_q == '0);
	assign stat.addr_last = (CW'(addr_q) == fill_q - CW'(1));

	// Result for items that finish at acceptance
	always_comb begin
		imm_res = '0;
		case (in_item.func) inside
			FUNC_LOAD: begin
				if (!len_ok) begin
					imm_res.status = STAT_BADLEN;
				end else if (full) begin
					imm_res.status       = STAT_FULL;
					imm_res.bucket_count = CNT_W'(slot_cnt);
				end else begin
					imm_res.status       = STAT_OK;
					imm_res.bucket_count = CNT_W'(slot_cnt + CW'(1));
				end
			end
			FUNC_QUERY: begin
				imm_res.status = STAT_BADLEN;
			end
			FUNC_CLEAR, FUNC_NONE: begin
				imm_res = '0;
			end
			default: begin
				imm_res = '0;
			end
		endcase
	end

	always_comb begin
		qry_res = '0;
		qry_res.bucket_count = CNT_W'(cnt_q[qslot_q]);
		if (hit_q) begin
			qry_res.status   = STAT_OK;
			qry_res.found    = 1'b1;
			qry_res.position = POS_W'(smaller_q);
		end else begin
			qry_res.status = STAT_MISS;
		end
	end

	// Fill and bucket counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			for (int i = 0; i < WORD_CHARS; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (do_clear) begin
			fill_q <= '0;
			for (int i = 0; i < WORD_CHARS; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (do_load) begin
			fill_q      <= fill_q + CW'(1);
			cnt_q[slot] <= cnt_q[slot] + CW'(1);
		end
	end

	// Entry memory: append on load, one registered read per scan cycle
	always_ff @(posedge clk) begin
		if (do_load) begin
			mem_q[fill_q[AW-1:0]] <= {in_item.word_length, in_word_m};
		end
		if (cmd.rd_en) begin
			rd_data_s1 <= mem_q[addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.rd_en;
		end
	end

	assign ent_word = rd_data_s1[WW-1:0];
	assign ent_len  = rd_data_s1[EW-1 -: LEN_W];

	// Scan address, query operands and rank accumulation
	always_ff @(posedge clk) begin
		if (cmd.start_query) begin
			addr_q    <= '0;
			qword_q   <= in_word_m;
			qlen_q    <= in_item.word_length;
			qslot_q   <= slot;
			smaller_q <= '0;
			hit_q     <= 1'b0;
		end else begin
			if (cmd.rd_en) begin
				addr_q <= addr_q + AW'(1);
			end
			if (rd_valid_s1 && (ent_len == qlen_q)) begin
				if (ent_word < qword_q) begin
					smaller_q <= smaller_q + CW'(1);
				end else if (ent_word == qword_q) begin
					hit_q <= 1'b1;
				end
			end
		end
	end

	// Result register: hold until taken (controller admits no overwrite)
	always_ff @(posedge clk) begin
		if (cmd.immediate) begin
			out_q <= imm_res;
		end else if (cmd.query_done) begin
			out_q <= qry_res;
		end
	end

	assign out_item = out_q;

endmodule

// File: rtl/core/word_dictionary_rank_lookup.sv
// Top level of the word dictionary rank lookup block.
// Depends on wdrl_pkg, wdrl_ctrl and wdrl_dp.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+---------------------------
//   input   | in_valid  | in_stall  | in_item  (func, word, word_length)
//   output  | out_valid | out_stall | out_item (status, found, position,
//           |           |           |           bucket_count)
//
// Clear, load, unused and bad-length items finish in the accept cycle; the
// result is in the output register the next cycle.
// A query scans the entry memory one stored entry per cycle through its single
// read port.
// One item at a time; a new transaction is taken only when the output register
// is empty or its result leaves in that same cycle, and never during a query.
// Reset clears the fill and bucket counters, controller state and valid flags;
// the memory needs no clearing as only entries below the fill count are read.
module word_dictionary_rank_lookup #(
	parameter int TABLE_DEPTH = wdrl_pkg::DEFAULT_TABLE_DEPTH,
	parameter int WORD_CHARS  = wdrl_pkg::DEFAULT_WORD_CHARS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  wdrl_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output wdrl_pkg::out_item_t out_item
);
	import wdrl_pkg::*;

	// Command and status between the controller and the datapath
	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Sequence accept, scan, drain and respond; own both handshakes
	wdrl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Store entries, count buckets, rank the query word, hold the result
	wdrl_dp #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.WORD_CHARS  (WORD_CHARS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (in_item),
		.cmd      (cmd),
		.stat     (stat),
		.out_item (out_item)
	);

endmodule
